// ===== rtl/cna_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
// Depends on nothing; every other rtl file imports it.
`default_nettype none

package cna_pkg;

    localparam int WORD_W     = 32;
    localparam int DIV_W      = 16;
    localparam int ITER_STEPS = 32;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    // incoming operation codes
    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_CONJ = 3'd3;
    localparam logic [2:0] MODE_MAG  = 3'd4;
    localparam logic [2:0] MODE_DIV  = 3'd5;

    // classified operation, as the back end sees it
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_CONJ,
        OP_MAG,
        OP_DIV,
        OP_DIVZ,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef struct packed {
        logic        [2:0]  mode;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
        logic signed [15:0] divisor;
    } cna_in_t;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic        [1:0]  status;
    } cna_out_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
        logic signed [15:0] divisor;
    } cmd_t;

    // state carried through the iterative square root / divide stages
    typedef struct packed {
        op_t         op;
        logic [31:0] res_re;
        logic [31:0] res_im;
        status_t     status;
        logic [63:0] rad;
        logic [33:0] srem;
        logic [31:0] root;
        logic [31:0] dq_re;
        logic [15:0] dr_re;
        logic [31:0] dq_im;
        logic [15:0] dr_im;
        logic [15:0] dabs;
        logic        neg_re;
        logic        neg_im;
    } iter_t;

endpackage

`default_nettype wire

// ===== rtl/cna_front.sv =====
// Front end: takes input words, classifies the operation, flags divide by zero.
// Depends on cna_pkg.
`default_nettype none

module cna_front (
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire cna_pkg::cna_in_t s_data,
    output logic                  cmd_valid,
    input  wire                   cmd_ready,
    output cna_pkg::cmd_t         cmd
);
    import cna_pkg::*;

    op_t op;

    always_comb begin
        unique case (s_data.mode)
            MODE_ADD:  op = OP_ADD;
            MODE_SUB:  op = OP_SUB;
            MODE_MUL:  op = OP_MUL;
            MODE_CONJ: op = OP_CONJ;
            MODE_MAG:  op = OP_MAG;
            MODE_DIV:  op = (s_data.divisor == '0) ? OP_DIVZ : OP_DIV;
            default:   op = OP_NONE;
        endcase
    end

    always_comb begin
        cmd.op      = op;
        cmd.a_re    = s_data.a_re;
        cmd.a_im    = s_data.a_im;
        cmd.b_re    = s_data.b_re;
        cmd.b_im    = s_data.b_im;
        cmd.divisor = s_data.divisor;
    end

    assign cmd_valid = s_valid;
    assign s_ready   = cmd_ready;

endmodule

`default_nettype wire

// ===== rtl/cna_queue.sv =====
// Short queue of classified commands between front and back end.
// Depends on cna_pkg.
`default_nettype none

module cna_queue #(
    parameter int DEPTH = 4
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire cna_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire                out_ready,
    output cna_pkg::cmd_t      out_cmd
);
    import cna_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cna_back.sv =====
// Back end: multiply stage, combine stage, 32 square root / divide steps, result register.
// Depends on cna_pkg.
`default_nettype none

module cna_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cmd_valid,
    output logic               cmd_ready,
    input  wire cna_pkg::cmd_t cmd,
    output logic               m_valid,
    input  wire                m_ready,
    output cna_pkg::cna_out_t  m_data
);
    import cna_pkg::*;

    localparam logic [65:0] HALF = 66'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        op_t                op;
        logic signed [63:0] p_rr;
        logic signed [63:0] p_ii;
        logic signed [63:0] p_ri;
        logic signed [63:0] p_ir;
        logic signed [32:0] as_re;
        logic signed [32:0] as_im;
        logic        [31:0] nabs_re;
        logic        [31:0] nabs_im;
        logic        [15:0] dabs;
        logic               neg_re;
        logic               neg_im;
    } prod_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } clip_t;

    function automatic clip_t clip66(input logic [65:0] v);
        clip_t c;
        logic [34:0] hi;
        hi = v[65:31];
        c.sat = !((&hi) || !(|hi));
        c.val = c.sat ? (v[65] ? WORD_MIN : WORD_MAX) : v[31:0];
        return c;
    endfunction

    function automatic iter_t step(input iter_t x);
        iter_t       y;
        logic [34:0] t;
        logic [34:0] trial;
        logic [16:0] tr;
        logic [16:0] ti;
        y     = x;
        t     = {x.srem[32:0], x.rad[63:62]};
        trial = {1'b0, x.root, 2'b01};
        if (t >= trial) begin
            y.srem = 34'(t - trial);
            y.root = {x.root[30:0], 1'b1};
        end else begin
            y.srem = t[33:0];
            y.root = {x.root[30:0], 1'b0};
        end
        y.rad = {x.rad[61:0], 2'b00};
        tr = {x.dr_re, x.dq_re[31]};
        if (tr >= {1'b0, x.dabs}) begin
            y.dr_re = 16'(tr - {1'b0, x.dabs});
            y.dq_re = {x.dq_re[30:0], 1'b1};
        end else begin
            y.dr_re = tr[15:0];
            y.dq_re = {x.dq_re[30:0], 1'b0};
        end
        ti = {x.dr_im, x.dq_im[31]};
        if (ti >= {1'b0, x.dabs}) begin
            y.dr_im = 16'(ti - {1'b0, x.dabs});
            y.dq_im = {x.dq_im[30:0], 1'b1};
        end else begin
            y.dr_im = ti[15:0];
            y.dq_im = {x.dq_im[30:0], 1'b0};
        end
        return y;
    endfunction

    logic     advance;
    prod_t    pa_reg, pa_next;
    logic     va_reg;
    iter_t    it_reg  [ITER_STEPS + 1];
    iter_t    it_next [ITER_STEPS + 1];
    logic     vit_reg [ITER_STEPS + 1];
    cna_out_t m_data_reg, m_data_next;
    logic     m_valid_reg;

    assign advance   = !m_valid_reg || m_ready;
    assign cmd_ready = advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // products, sums and operand magnitudes
    always_comb begin
        logic signed [31:0] br;
        logic signed [31:0] bi;
        br = (cmd.op == OP_MAG) ? cmd.a_re : cmd.b_re;
        bi = (cmd.op == OP_MAG) ? cmd.a_im : cmd.b_im;
        pa_next.op   = cmd.op;
        pa_next.p_rr = cmd.a_re * br;
        pa_next.p_ii = cmd.a_im * bi;
        pa_next.p_ri = cmd.a_re * bi;
        pa_next.p_ir = cmd.a_im * br;
        case (cmd.op)
            OP_ADD: begin
                pa_next.as_re = {cmd.a_re[31], cmd.a_re} + {cmd.b_re[31], cmd.b_re};
                pa_next.as_im = {cmd.a_im[31], cmd.a_im} + {cmd.b_im[31], cmd.b_im};
            end
            OP_SUB: begin
                pa_next.as_re = {cmd.a_re[31], cmd.a_re} - {cmd.b_re[31], cmd.b_re};
                pa_next.as_im = {cmd.a_im[31], cmd.a_im} - {cmd.b_im[31], cmd.b_im};
            end
            default: begin
                pa_next.as_re = {cmd.a_re[31], cmd.a_re};
                pa_next.as_im = 33'sd0 - {cmd.a_im[31], cmd.a_im};
            end
        endcase
        pa_next.nabs_re = cmd.a_re[31] ? (~cmd.a_re + 32'd1) : cmd.a_re;
        pa_next.nabs_im = cmd.a_im[31] ? (~cmd.a_im + 32'd1) : cmd.a_im;
        pa_next.dabs    = cmd.divisor[15] ? (~cmd.divisor + 16'd1) : cmd.divisor;
        pa_next.neg_re  = cmd.a_re[31] ^ cmd.divisor[15];
        pa_next.neg_im  = cmd.a_im[31] ^ cmd.divisor[15];
    end

    // finish the single-pass operations, seed the iterative ones
    always_comb begin
        logic [65:0] s_re;
        logic [65:0] s_im;
        clip_t       c_re;
        clip_t       c_im;
        s_re = 66'(pa_reg.p_rr) - 66'(pa_reg.p_ii) + HALF;
        s_im = 66'(pa_reg.p_ri) + 66'(pa_reg.p_ir) + HALF;
        s_re = 66'($signed(s_re) >>> FRAC_BITS);
        s_im = 66'($signed(s_im) >>> FRAC_BITS);
        if (pa_reg.op != OP_MUL) begin
            s_re = 66'(pa_reg.as_re);
            s_im = 66'(pa_reg.as_im);
        end
        c_re = clip66(s_re);
        c_im = clip66(s_im);

        it_next[0]        = '0;
        it_next[0].op     = pa_reg.op;
        it_next[0].rad    = pa_reg.p_rr + pa_reg.p_ii;
        it_next[0].dq_re  = pa_reg.nabs_re;
        it_next[0].dq_im  = pa_reg.nabs_im;
        it_next[0].dabs   = pa_reg.dabs;
        it_next[0].neg_re = pa_reg.neg_re;
        it_next[0].neg_im = pa_reg.neg_im;
        it_next[0].status = ST_OK;
        unique case (pa_reg.op)
            OP_ADD, OP_SUB, OP_MUL: begin
                it_next[0].res_re = c_re.val;
                it_next[0].res_im = c_im.val;
                it_next[0].status = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
            end
            OP_CONJ: begin
                it_next[0].res_re = pa_reg.as_re[31:0];
                it_next[0].res_im = c_im.val;
                it_next[0].status = c_im.sat ? ST_SAT : ST_OK;
            end
            OP_DIVZ: it_next[0].status = ST_DIVZ;
            default: it_next[0].status = ST_OK;
        endcase
    end

    for (genvar k = 1; k <= ITER_STEPS; k++) begin : g_step
        always_comb begin
            it_next[k] = step(it_reg[k-1]);
        end
    end

    // round the root, sign the quotients, clip
    always_comb begin
        iter_t       x;
        logic [32:0] mag;
        logic [32:0] q_re;
        logic [32:0] q_im;
        clip_t       c_re;
        clip_t       c_im;
        x    = it_reg[ITER_STEPS];
        mag  = {1'b0, x.root} + 33'({2'b00, x.root} < x.srem);
        q_re = x.neg_re ? (33'd0 - {1'b0, x.dq_re}) : {1'b0, x.dq_re};
        q_im = x.neg_im ? (33'd0 - {1'b0, x.dq_im}) : {1'b0, x.dq_im};
        c_re = clip66(66'($signed(q_re)));
        c_im = clip66(66'($signed(q_im)));
        m_data_next.res_re = x.res_re;
        m_data_next.res_im = x.res_im;
        m_data_next.status = x.status;
        unique case (x.op)
            OP_MAG: begin
                m_data_next.res_re = (mag[32] || mag[31]) ? WORD_MAX : mag[31:0];
                m_data_next.res_im = '0;
                m_data_next.status = (mag[32] || mag[31]) ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                m_data_next.res_re = c_re.val;
                m_data_next.res_im = c_im.val;
                m_data_next.status = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= ITER_STEPS; k++) begin
                vit_reg[k] <= 1'b0;
            end
        end else if (advance) begin
            va_reg      <= cmd_valid;
            vit_reg[0]  <= va_reg;
            for (int k = 1; k <= ITER_STEPS; k++) begin
                vit_reg[k] <= vit_reg[k-1];
            end
            m_valid_reg <= vit_reg[ITER_STEPS];
        end
    end

    // hold every stage while the result word waits
    always_ff @(posedge aclk) begin
        if (advance) begin
            pa_reg     <= pa_next;
            m_data_reg <= m_data_next;
            for (int k = 0; k <= ITER_STEPS; k++) begin
                it_reg[k] <= it_next[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/complex_number_alu_unit.sv =====
// Top level of the complex arithmetic unit: front end, command queue, back end.
// Depends on cna_pkg, cna_front, cna_queue, cna_back.
//
//   channel   direction  handshake          word
//   s_        in         s_valid / s_ready  cna_in_t  (mode, operands, divisor)
//   m_        out        m_valid / m_ready  cna_out_t (res_re, res_im, status)
//
// One word per cycle sustained while m_ready is not holding the back end; each word passes through
// the back end stages (product stage, combine stage, 32 square root / divide steps, result register).
// The back end pipeline advances whenever its result register is free or being taken.
// The queue keeps accepting words while the back end is held by m_ready, until the queue is full.
// Reset is synchronous on aresetn low and empties the queue and pipeline.
`default_nettype none

module complex_number_alu_unit #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire cna_pkg::cna_in_t s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output cna_pkg::cna_out_t     m_data
);
    import cna_pkg::*;

    cmd_t f_cmd;
    cmd_t q_cmd;
    logic f_valid, f_ready;
    logic q_valid, q_ready;

    cna_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    cna_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    cna_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for complex_number_alu_unit: directed and random complex operations,
// checked word by word against a behavioural predictor written here.
// Depends on cna_pkg and the rtl of complex_number_alu_unit.
`timescale 1ns / 1ps

module testbench;
    import cna_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 40;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    cna_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    cna_out_t  m_data;

    cna_out_t  expected_q[$];
    int        mismatches;
    int        words_sent;
    int        words_checked;
    longint    cycles;
    bit        src_idle_on;
    bit        snk_idle_on;
    int        hold_off;

    complex_number_alu_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint sat_word(input longint x, inout bit sat);
        if (x > WMAX) begin
            sat = 1'b1;
            return WMAX;
        end
        if (x < WMIN) begin
            sat = 1'b1;
            return WMIN;
        end
        return x;
    endfunction

    // round((p + q) / 2^FRAC) to nearest, ties up, computed exactly in 128 bits
    function automatic longint round_scaled(input longint p, input longint q);
        logic signed [127:0] s;
        s = 128'(signed'(p)) + 128'(signed'(q)) + (128'sd1 <<< (FRAC - 1));
        s = s >>> FRAC;
        return longint'(s);
    endfunction

    function automatic longint root_round(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] rem;
        logic [64:0] trial;
        r = '0;
        rem = '0;
        for (int i = 31; i >= 0; i--) begin
            rem = (rem << 2) | ((s >> (2 * i)) & 64'd3);
            trial = {r[62:0], 2'b01};
            if ({1'b0, rem} >= trial) begin
                rem = rem - trial[63:0];
                r = (r << 1) | 64'd1;
            end else begin
                r = r << 1;
            end
        end
        if (rem > r) r = r + 64'd1;
        return longint'(r);
    endfunction

    function automatic cna_out_t complex_result(input cna_in_t w);
        longint ar, ai, br, bi, d, rr, ri;
        logic [63:0] sq;
        bit sat;
        status_t st;
        cna_out_t o;
        ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im; d = w.divisor;
        rr = 0; ri = 0; sat = 1'b0; st = ST_OK;
        case (w.mode)
            MODE_ADD: begin
                rr = sat_word(ar + br, sat);
                ri = sat_word(ai + bi, sat);
            end
            MODE_SUB: begin
                rr = sat_word(ar - br, sat);
                ri = sat_word(ai - bi, sat);
            end
            MODE_MUL: begin
                rr = sat_word(round_scaled(ar * br, -(ai * bi)), sat);
                ri = sat_word(round_scaled(ar * bi, ai * br), sat);
            end
            MODE_CONJ: begin
                rr = ar;
                ri = sat_word(-ai, sat);
            end
            MODE_MAG: begin
                sq = 64'(ar * ar) + 64'(ai * ai);
                rr = root_round(sq);
                if (rr > WMAX) begin
                    rr = WMAX;
                    sat = 1'b1;
                end
            end
            MODE_DIV: begin
                if (d == 0) st = ST_DIVZ;
                else begin
                    rr = sat_word(ar / d, sat);
                    ri = sat_word(ai / d, sat);
                end
            end
            default: ;
        endcase
        if (sat && st == ST_OK) st = ST_SAT;
        o.res_re = rr[31:0];
        o.res_im = ri[31:0];
        o.status = st;
        return o;
    endfunction

    // random gaps on the source side
    task automatic idle_source();
        if (src_idle_on) begin
            while ($urandom_range(99) < 35) @(posedge aclk);
        end
    endtask

    // valid stays high between back to back words; drop it only for a gap
    task automatic send_word(input cna_in_t w);
        if (src_idle_on && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            idle_source();
        end
        s_valid <= 1'b1;
        s_data  <= w;
        expected_q.push_back(complex_result(w));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF - $urandom_range(3);
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return $urandom_range(16'hFFFF) - 32'h8000;
            3: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic cna_in_t rand_item(input logic [2:0] mode);
        cna_in_t w;
        w.mode = mode;
        w.a_re = rand_word();
        w.a_im = rand_word();
        w.b_re = rand_word();
        w.b_im = rand_word();
        case ($urandom_range(4))
            0: w.divisor = 16'd0;
            1: w.divisor = 16'hFFFF;
            2: w.divisor = 16'($urandom_range(7)) - 16'd3;
            default: w.divisor = 16'($urandom);
        endcase
        return w;
    endfunction

    function automatic cna_in_t make_item(input logic [2:0] mode, input logic [31:0] ar,
                                          input logic [31:0] ai, input logic [31:0] br,
                                          input logic [31:0] bi, input logic [15:0] d);
        cna_in_t w;
        w.mode = mode; w.a_re = ar; w.a_im = ai; w.b_re = br; w.b_im = bi; w.divisor = d;
        return w;
    endfunction

    task automatic test_directed();
        send_word(make_item(MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF,
                            16'd0));
        send_word(make_item(MODE_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'd5, '0));
        send_word(make_item(MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, '0));
        send_word(make_item(MODE_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, '0));
        send_word(make_item(MODE_MUL, 32'h0001_8000, 32'h0000_8000, 32'h0002_0000,
                            32'h0001_0000, '0));
        send_word(make_item(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, '0));
        send_word(make_item(MODE_MUL, 32'd1, 32'd0, 32'h0000_8000, 32'd0, '0));
        send_word(make_item(MODE_MUL, 32'hFFFF_FFFF, 32'd0, 32'h0000_8000, 32'd0, '0));
        send_word(make_item(MODE_CONJ, 32'h1234_5678, 32'h8000_0000, '0, '0, '0));
        send_word(make_item(MODE_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0));
        send_word(make_item(MODE_MAG, 32'h0003_0000, 32'h0004_0000, '0, '0, '0));
        send_word(make_item(MODE_MAG, 32'h8000_0000, 32'h8000_0000, '0, '0, '0));
        send_word(make_item(MODE_MAG, 32'h7FFF_FFFF, 32'd0, '0, '0, '0));
        send_word(make_item(MODE_MAG, 32'd0, 32'd0, '0, '0, '0));
        send_word(make_item(MODE_DIV, 32'h8000_0000, 32'h8000_0000, '0, '0, 16'hFFFF));
        send_word(make_item(MODE_DIV, 32'hFFFF_FFF9, 32'd7, '0, '0, 16'd2));
        send_word(make_item(MODE_DIV, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 16'h8000));
        send_word(make_item(MODE_DIV, 32'h7FFF_FFFF, 32'd1, '0, '0, 16'h7FFF));
        send_word(make_item(MODE_DIV, 32'd5, 32'd5, '0, '0, 16'd0));
        send_word(make_item(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            16'hFFFF));
        send_word(make_item(3'd7, 32'd1, 32'd1, 32'd1, 32'd1, 16'd1));
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_word(rand_item(3'($urandom_range(7))));
    endtask

    // sink stalls for a long while so the queue fills and s_ready drops
    task automatic test_backpressure();
        hold_off = 300;
        test_random(60);
        drain();
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn) begin
            cycles <= cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: re=%h im=%h st=%0d",
                                 m_data.res_re, m_data.res_im, m_data.status);
                end else begin
                    cna_out_t e;
                    e = expected_q.pop_front();
                    words_checked++;
                    if (e !== m_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp re=%h im=%h st=%0d,",
                                      " got re=%h im=%h st=%0d"},
                                     e.res_re, e.res_im, e.status,
                                     m_data.res_re, m_data.res_im, m_data.status);
                    end
                end
            end
        end
    end

    // sink: long hold-off counted here, random idling otherwise
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(snk_idle_on && $urandom_range(99) < 35);
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        cycles = 0;
        hold_off = 0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        drain();
        test_backpressure();
        test_random(600);
        // long stretch with no idling on either side
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        test_random(400);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        test_random(570);
        drain();

        $display("sent %0d words over all modes incl. saturation and divide by zero",
                 words_sent);
        $display("checked %0d result words", words_checked);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("%0d mismatches, %0d words outstanding", mismatches, expected_q.size());
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
